[sv/psg_pkg.sv]
// Package for the PAST speed governor: field widths, derived datapath widths,
// register indexes and register reset values.
// No dependencies; imported by past_speed_governor.
`timescale 1ns / 1ps

package psg_pkg;

    // full speed in scaled units
    localparam int SCALE = 1000;

    localparam int IDLE_W    = 16;
    localparam int IL_W      = 16;
    localparam int LOAD_W    = 10;
    localparam int SPEED_W   = 10;
    localparam int FREQ_W    = 30;
    localparam int EXC_W     = 32;
    localparam int CFG_W     = FREQ_W;
    localparam int CFG_IDX_W = 3;

    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int RUN_W   = EXC_W + 1;
    localparam int SUM_W   = RUN_W + 1;
    localparam int PROD_W  = RUN_W + SCALE_W;
    localparam int LOADP_W = SUM_W + SPEED_W;
    localparam int TOPP_W  = FREQ_W + SPEED_W;
    localparam int MUL_W   = (LOADP_W > TOPP_W) ? LOADP_W : TOPP_W;
    localparam int DIV_W   = (PROD_W > MUL_W) ? PROD_W : MUL_W;
    localparam int DVS_W   = (IL_W > SCALE_W) ? IL_W : SCALE_W;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int NSP_W   = SPEED_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL  = 3'd0,
        REG_HIGH_LOAD = 3'd1,
        REG_LOW_LOAD  = 3'd2,
        REG_RAISE     = 3'd3,
        REG_LOWER     = 3'd4,
        REG_FLOOR     = 3'd5,
        REG_CEILING   = 3'd6,
        REG_TOP_FREQ  = 3'd7
    } cfg_reg_t;

    localparam logic [IL_W-1:0]    INTERVAL_RST  = 16'd50;
    localparam logic [LOAD_W-1:0]  HIGH_LOAD_RST = 10'd700;
    localparam logic [LOAD_W-1:0]  LOW_LOAD_RST  = 10'd500;
    localparam logic [SPEED_W-1:0] RAISE_RST     = 10'd200;
    localparam logic [SPEED_W-1:0] LOWER_RST     = 10'd600;
    localparam logic [SPEED_W-1:0] FLOOR_RST     = 10'd200;
    localparam logic [SPEED_W-1:0] CEILING_RST   = 10'd1000;
    localparam logic [FREQ_W-1:0]  TOP_FREQ_RST  = 30'd48000000;

endpackage

[sv/past_speed_governor.sv]
// PAST speed governor top level: run time, run percentage, PAST speed rules,
// carried excess and output clock frequency. Depends on psg_pkg.
`timescale 1ns / 1ps

//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  item      | item_valid / item_stall    | idle_time
//  result    | result_valid / result_stall| speed_level, clock_hz
//  config    | cfg_write                  | cfg_index, cfg_data
//
// Each item goes through accept, setup, then three passes of a shared
// restoring divider at one quotient bit per cycle over a DIV_W (44) bit
// dividend (run percentage, excess / SCALE, frequency / SCALE), plus the rule
// cycle and the output cycle. A shift-add multiplier runs beside the divider.
// Reset restores the register defaults, speed to the ceiling, excess to zero.
// A new item is taken while a result waits; the finished one holds in the
// last cycle until the result register is free.

module past_speed_governor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [psg_pkg::IDLE_W-1:0]    idle_time,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [psg_pkg::SPEED_W-1:0]   speed_level,
    output logic [psg_pkg::FREQ_W-1:0]    clock_hz,
    input  logic                          cfg_write,
    input  logic [psg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psg_pkg::CFG_W-1:0]     cfg_data
);
    import psg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CALC,
        S_RULES,
        S_EXCESS,
        S_FREQ,
        S_DONE
    } state_t;

    // configuration
    logic [IL_W-1:0]    il_reg;
    logic [LOAD_W-1:0]  high_load_reg;
    logic [LOAD_W-1:0]  low_load_reg;
    logic [SPEED_W-1:0] raise_reg;
    logic [SPEED_W-1:0] lower_reg;
    logic [SPEED_W-1:0] floor_reg;
    logic [SPEED_W-1:0] ceil_reg;
    logic [FREQ_W-1:0]  top_reg;

    // control and state
    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               result_valid_reg;
    logic [SPEED_W-1:0] cur_speed_reg;
    logic [EXC_W-1:0]   excess_reg;

    // datapath
    logic [RUN_W-1:0]   run_reg;
    logic [IDLE_W-1:0]  idle_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIV_W-1:0]   q_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [MUL_W-1:0]   mcand_reg;
    logic [SPEED_W-1:0] mplier_reg;
    logic [MUL_W-1:0]   acc_reg;
    logic [SPEED_W-1:0] speed_new_reg;
    logic [EXC_W-1:0]   exc_new_reg;
    logic [SPEED_W-1:0] speed_out_reg;
    logic [FREQ_W-1:0]  clock_out_reg;

    // combinational
    logic [IL_W-1:0]    run_base;
    logic [RUN_W-1:0]   run_next;
    logic [SUM_W-1:0]   sum;
    logic [PROD_W-1:0]  prod_next;
    logic [DVS_W:0]     rem_sh;
    logic [DVS_W:0]     rem_sub;
    logic               rem_ge;
    logic [DVS_W-1:0]   rem_step;
    logic [DIV_W-1:0]   q_step;
    logic [MUL_W-1:0]   acc_step;
    logic               last_step;
    logic               pct_hi;
    logic               pct_lo;
    logic signed [NSP_W-1:0] cur_s;
    logic signed [NSP_W-1:0] ceil_s;
    logic signed [NSP_W-1:0] floor_s;
    logic signed [NSP_W-1:0] nsp_raw;
    logic signed [NSP_W-1:0] nsp_ceil;
    logic signed [NSP_W-1:0] nsp_fin;
    logic [SPEED_W-1:0] speed_next;
    logic [DIV_W-1:0]   prod_ext;
    logic [DIV_W-1:0]   load_ext;
    logic [DIV_W-1:0]   diff;
    logic [EXC_W-1:0]   exc_sat;
    logic [FREQ_W-1:0]  freq_sat;
    logic               out_free;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign speed_level  = speed_out_reg;
    assign clock_hz     = clock_out_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // run time floored at zero plus carried excess
    assign run_base  = (idle_time >= il_reg) ? '0 : il_reg - idle_time;
    assign run_next  = RUN_W'(run_base) + RUN_W'(excess_reg);
    assign sum       = SUM_W'(run_reg) + SUM_W'(idle_reg);
    assign prod_next = PROD_W'(run_reg) * PROD_W'(SCALE);

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {rem_reg, q_reg[DIV_W-1]};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign rem_ge   = (rem_sh >= {1'b0, dvs_reg});
    assign rem_step = rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    assign q_step   = {q_reg[DIV_W-2:0], rem_ge};

    // shift-add multiplier, one multiplier bit per cycle
    assign acc_step  = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
    assign last_step = (cnt_reg == CNT_W'(DIV_W - 1));

    // PAST rules; q_reg holds the run percentage in S_RULES
    assign pct_hi  = (q_reg > DIV_W'(high_load_reg));
    assign pct_lo  = (q_reg < DIV_W'(low_load_reg));
    assign cur_s   = $signed(NSP_W'(cur_speed_reg));
    assign ceil_s  = $signed(NSP_W'(ceil_reg));
    assign floor_s = $signed(NSP_W'(floor_reg));

    always_comb
    begin
        if (excess_reg > EXC_W'(idle_reg))
        begin
            nsp_raw = ceil_s;
        end
        else if (pct_hi)
        begin
            nsp_raw = cur_s + $signed(NSP_W'(raise_reg));
        end
        else if (pct_lo)
        begin
            // percentage is below low_load here, so it fits LOAD_W bits
            nsp_raw = cur_s - $signed(NSP_W'(lower_reg))
                      + $signed(NSP_W'(q_reg[LOAD_W-1:0]));
        end
        else
        begin
            nsp_raw = cur_s;
        end
    end

    // ceiling first, floor wins when the two cross
    assign nsp_ceil   = (nsp_raw > ceil_s) ? ceil_s : nsp_raw;
    assign nsp_fin    = (nsp_ceil < floor_s) ? floor_s : nsp_ceil;
    assign speed_next = nsp_fin[SPEED_W-1:0];

    assign prod_ext = DIV_W'(prod_reg);
    assign load_ext = DIV_W'(acc_reg);
    assign diff     = (prod_ext > load_ext) ? prod_ext - load_ext : '0;

    assign exc_sat  = (|q_step[DIV_W-1:EXC_W]) ? '1 : q_step[EXC_W-1:0];
    assign freq_sat = (|q_reg[DIV_W-1:FREQ_W]) ? '1 : q_reg[FREQ_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            il_reg        <= INTERVAL_RST;
            high_load_reg <= HIGH_LOAD_RST;
            low_load_reg  <= LOW_LOAD_RST;
            raise_reg     <= RAISE_RST;
            lower_reg     <= LOWER_RST;
            floor_reg     <= FLOOR_RST;
            ceil_reg      <= CEILING_RST;
            top_reg       <= TOP_FREQ_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INTERVAL:  il_reg        <= cfg_data[IL_W-1:0];
                REG_HIGH_LOAD: high_load_reg <= cfg_data[LOAD_W-1:0];
                REG_LOW_LOAD:  low_load_reg  <= cfg_data[LOAD_W-1:0];
                REG_RAISE:     raise_reg     <= cfg_data[SPEED_W-1:0];
                REG_LOWER:     lower_reg     <= cfg_data[SPEED_W-1:0];
                REG_FLOOR:     floor_reg     <= cfg_data[SPEED_W-1:0];
                REG_CEILING:   ceil_reg      <= cfg_data[SPEED_W-1:0];
                REG_TOP_FREQ:  top_reg       <= cfg_data[FREQ_W-1:0];
                default:       top_reg       <= top_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            cur_speed_reg    <= CEILING_RST;
            excess_reg       <= '0;
            run_reg          <= '0;
            idle_reg         <= '0;
            prod_reg         <= '0;
            q_reg            <= '0;
            rem_reg          <= '0;
            dvs_reg          <= '0;
            mcand_reg        <= '0;
            mplier_reg       <= '0;
            acc_reg          <= '0;
            speed_new_reg    <= '0;
            exc_new_reg      <= '0;
            speed_out_reg    <= '0;
            clock_out_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        run_reg   <= run_next;
                        idle_reg  <= idle_time;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    prod_reg   <= prod_next;
                    q_reg      <= DIV_W'(prod_next);
                    rem_reg    <= '0;
                    dvs_reg    <= (il_reg == '0) ? DVS_W'(1) : DVS_W'(il_reg);
                    mcand_reg  <= MUL_W'(sum);
                    mplier_reg <= cur_speed_reg;
                    acc_reg    <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= S_CALC;
                end
                S_CALC:
                begin
                    q_reg      <= q_step;
                    rem_reg    <= rem_step;
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    if (last_step)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_RULES;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_RULES:
                begin
                    speed_new_reg <= speed_next;
                    q_reg         <= diff;
                    rem_reg       <= '0;
                    dvs_reg       <= DVS_W'(SCALE);
                    mcand_reg     <= MUL_W'(top_reg);
                    mplier_reg    <= speed_next;
                    acc_reg       <= '0;
                    state_reg     <= S_EXCESS;
                end
                S_EXCESS:
                begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    if (last_step)
                    begin
                        // multiplier finished long ago: start frequency / SCALE
                        exc_new_reg <= exc_sat;
                        q_reg       <= DIV_W'(acc_reg);
                        rem_reg     <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= S_FREQ;
                    end
                    else
                    begin
                        q_reg   <= q_step;
                        rem_reg <= rem_step;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_FREQ:
                begin
                    q_reg   <= q_step;
                    rem_reg <= rem_step;
                    if (last_step)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        speed_out_reg    <= speed_new_reg;
                        clock_out_reg    <= freq_sat;
                        cur_speed_reg    <= speed_new_reg;
                        excess_reg       <= exc_new_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a new result only comes out of the output cycle
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_DONE))
        else $error("result_valid rose outside the output cycle");

    // governor state is committed only with a result
    a_excess_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(excess_reg) |-> $past(state_reg == S_DONE))
        else $error("excess changed outside the output cycle");

    a_speed_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cur_speed_reg) |-> $past(state_reg == S_DONE && out_free))
        else $error("speed changed without a delivered result");

    // a zero interval must have been replaced by one before dividing
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC || state_reg == S_EXCESS || state_reg == S_FREQ)
        |-> dvs_reg != '0)
        else $error("divider running with a zero divisor");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_PREP && cnt_reg == '0))
        else $error("accepted transaction did not start the sequence");

endmodule
